/* src/lse_pkg.sv */
// shared types and constants for the lsb stego extractor
package lse_pkg;

  localparam int HEADER_COMPONENTS = 3;
  localparam int COMP_W = 8;
  localparam int CHAR_W = 8;
  localparam int HDR_CNT_W = 2;
  localparam int BPC_W = 4;
  localparam int POS_W = 3;

  localparam logic [BPC_W-1:0] BPC_FULL = BPC_W'(8);
  localparam logic [POS_W-1:0] POS_TOP = POS_W'(7);
  localparam logic [CHAR_W-1:0] TERM_CHAR = '0;

  typedef struct packed {
    logic [HDR_CNT_W-1:0] header_count;
    logic [BPC_W-1:0]     bits_per_component;
    logic [CHAR_W-1:0]    byte_accumulator;
    logic [POS_W-1:0]     bit_position;
    logic                 message_done;
  } state_t;

  localparam state_t STATE_RESET = '{
    header_count:       '0,
    bits_per_component: '0,
    byte_accumulator:   '0,
    bit_position:       POS_TOP,
    message_done:       1'b0
  };

  typedef struct packed {
    logic [CHAR_W-1:0] char_byte;
    logic              last;
    logic              found_terminator;
  } result_t;

  typedef struct packed {
    logic [COMP_W-1:0] component;
    logic              start_of_image;
    logic              end_of_image;
  } item_t;

endpackage

/* src/lse_in_if.sv */
// input channel: pixel components with image framing
interface lse_in_if
  import lse_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] component;
  logic              start_of_image;
  logic              end_of_image;

  modport source (output valid, output component, output start_of_image,
                  output end_of_image, input ready);
  modport sink (input valid, input component, input start_of_image,
                input end_of_image, output ready);
endinterface

/* src/lse_out_if.sv */
// output channel: recovered message bytes
interface lse_out_if
  import lse_pkg::*;
();

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_byte;
  logic              last;
  logic              found_terminator;

  modport source (output valid, output char_byte, output last,
                  output found_terminator, input ready);
  modport sink (input valid, input char_byte, input last,
                input found_terminator, output ready);
endinterface

/* src/lsb_stego_extract.sv */
// lsb stego extractor top level: state registers and two-slot result buffer
// Recovers a message hidden in the low bits of pixel components. Each accepted
// component passes through combinational step logic and yields zero, one or two
// result items, which wait in a two-slot output buffer. One component is accepted
// per cycle whenever at most one buffered item remains and that one is being
// taken; a component that yields two items (a byte followed by the image-end
// terminator) fills both slots. The header is the bit 0 values of the first
// three components (0 means 8 bits per component).
module lsb_stego_extract
  import lse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  lse_in_if.sink     in_ch,
  lse_out_if.source  out_ch
);

  state_t     state;
  state_t     state_next;
  item_t      item;
  result_t    res0;
  result_t    res1;
  logic [1:0] res_count;
  result_t    slot0;
  result_t    slot1;
  logic [1:0] cnt;
  logic       accept;
  logic       pop;

  assign item = '{component: in_ch.component, start_of_image: in_ch.start_of_image,
                  end_of_image: in_ch.end_of_image};

  lse_step u_step (
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .res0       (res0),
    .res1       (res1),
    .res_count  (res_count)
  );

  assign in_ch.ready = (cnt == 2'd0) || (cnt == 2'd1 && out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  assign out_ch.valid            = (cnt != 2'd0);
  assign out_ch.char_byte        = slot0.char_byte;
  assign out_ch.last             = slot0.last;
  assign out_ch.found_terminator = slot0.found_terminator;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
      cnt   <= '0;
    end else if (accept) begin
      state <= state_next;
      cnt   <= res_count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("result buffer overfilled");

  a_last_at_tail: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !slot0.last)
    else $error("terminator followed by another item");

  a_bpc_valid: assert property (@(posedge clk) disable iff (rst)
    state.header_count == HDR_CNT_W'(HEADER_COMPONENTS) |->
      (state.bits_per_component != '0 && state.bits_per_component <= BPC_FULL))
    else $error("bits per component out of range after header");

  a_hdr_clean: assert property (@(posedge clk) disable iff (rst)
    state.header_count != HDR_CNT_W'(HEADER_COMPONENTS) |->
      (state.byte_accumulator == '0 && state.bit_position == POS_TOP))
    else $error("accumulator touched during header");

endmodule

/* src/lse_step.sv */
// per-component extraction logic: next state and up to two result items
module lse_step
  import lse_pkg::*;
(
  input  state_t     state,
  input  item_t      item,
  output state_t     state_next,
  output result_t    res0,
  output result_t    res1,
  output logic [1:0] res_count
);

  state_t            cur;
  logic [BPC_W-1:0]  bpc_hdr;
  logic [BPC_W-1:0]  b;
  logic [BPC_W-1:0]  free;
  logic [BPC_W-1:0]  rem;
  logic [CHAR_W-1:0] mask;
  logic [COMP_W-1:0] cl;
  logic [CHAR_W-1:0] done_byte;
  logic [CHAR_W-1:0] wide;

  always_comb begin
    cur        = item.start_of_image ? STATE_RESET : state;
    state_next = cur;
    res0       = '0;
    res1       = '0;
    res_count  = '0;
    bpc_hdr    = '0;
    b          = BPC_FULL;
    free       = '0;
    rem        = '0;
    mask       = '0;
    cl         = '0;
    done_byte  = '0;
    wide       = '0;

    if (!cur.message_done) begin
      if (cur.header_count < HDR_CNT_W'(HEADER_COMPONENTS)) begin
        bpc_hdr = cur.bits_per_component
                | BPC_W'({3'b000, item.component[0]} << cur.header_count);
        state_next.header_count = cur.header_count + HDR_CNT_W'(1);
        if (state_next.header_count == HDR_CNT_W'(HEADER_COMPONENTS) && bpc_hdr == '0) begin
          bpc_hdr = BPC_FULL;
        end
        state_next.bits_per_component = bpc_hdr;
      end else begin
        if (cur.bits_per_component == '0 || cur.bits_per_component > BPC_FULL) begin
          b = BPC_FULL;
        end else begin
          b = cur.bits_per_component;
        end
        mask = CHAR_W'((9'd1 << b) - 9'd1);
        cl   = item.component & mask;
        free = {1'b0, cur.bit_position} + BPC_W'(1);
        if (b < free) begin
          wide = cl << (free - b);
          state_next.byte_accumulator = cur.byte_accumulator | wide;
          state_next.bit_position     = cur.bit_position - b[POS_W-1:0];
        end else begin
          rem       = b - free;
          done_byte = cur.byte_accumulator | (cl >> rem);
          res_count = 2'd1;
          if (done_byte == TERM_CHAR) begin
            res0                        = '{char_byte: TERM_CHAR, last: 1'b1,
                                            found_terminator: 1'b1};
            state_next.message_done     = 1'b1;
            state_next.byte_accumulator = '0;
            state_next.bit_position     = POS_TOP;
          end else begin
            res0 = '{char_byte: done_byte, last: 1'b0, found_terminator: 1'b0};
            wide = cl << (BPC_FULL - rem);
            state_next.byte_accumulator = wide;
            state_next.bit_position     = POS_TOP - rem[POS_W-1:0];
          end
        end
      end
    end

    if (item.end_of_image && !state_next.message_done) begin
      state_next.message_done = 1'b1;
      if (res_count == 2'd0) begin
        res0 = '{char_byte: TERM_CHAR, last: 1'b1, found_terminator: 1'b0};
      end else begin
        res1 = '{char_byte: TERM_CHAR, last: 1'b1, found_terminator: 1'b0};
      end
      res_count = res_count + 2'd1;
    end
  end

endmodule
